// ----- rtl/csm_pkg.sv -----
// Shared types and constants for the sparse matrix store.
// Item structs, entry layout, operation and status codes, sequencer states.
// No dependencies.
package csm_pkg;

   // Field widths
   localparam int FUNC_W = 3;
   localparam int IDX_W  = 4;
   localparam int VAL_W  = 64;
   localparam int POS_W  = 4;
   localparam int STAT_W = 2;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_GET_ROW  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_GET_COL  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_GET_DIAG = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  row_index;
      logic [IDX_W-1:0]  col_index;
      logic [VAL_W-1:0]  write_value;
   } req_item_type;

   typedef struct packed {
      logic [VAL_W-1:0]  read_value;
      logic [POS_W-1:0]  position;
      logic [STAT_W-1:0] status;
      logic              last;
   } rsp_item_type;

   // One stored nonzero: column plus raw value word
   typedef struct packed {
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_BASE,
      S_LIMIT,
      S_FETCH,
      S_COMPARE,
      S_RESOLVE,
      S_UPDATE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INSERT,
      S_EMIT
   } seq_state_type;

endpackage

// ----- rtl/csm_entry_ram.sv -----
// Entry memory: column index and value word per stored nonzero.
// One write port, one registered read port. Uses csm_pkg::entry_type.
module csm_entry_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  csm_pkg::entry_type wdata,
   input  logic               re,
   input  logic [AW-1:0]      raddr,
   output csm_pkg::entry_type rdata
);

   csm_pkg::entry_type entry_mem_ff [DEPTH];
   csm_pkg::entry_type rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         entry_mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= entry_mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/csm_row_table.sv -----
// Row start pointers and entry count of the compressed row layout.
// One read mux; an insert raises every row start above the given row.
// Depends on nothing but its parameters.
module csm_row_table #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_ROWS+1)-1:0]    rd_idx,
   output logic [$clog2(MAX_ENTRIES+1)-1:0] rd_data,
   output logic [$clog2(MAX_ENTRIES+1)-1:0] count,
   input  logic                             ins,
   input  logic [$clog2(MAX_ROWS+1)-1:0]    ins_row
);

   localparam int CW    = $clog2(MAX_ENTRIES+1);
   localparam int RS_AW = $clog2(MAX_ROWS+1);

   logic [CW-1:0] rs_ff [MAX_ROWS+1];
   logic [CW-1:0] rs_in [MAX_ROWS+1];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // Insert: bump count and every start past the row
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i <= MAX_ROWS; i++) begin
         rs_in[i] = rs_ff[i];
         if (ins && (RS_AW'(i) > ins_row)) begin
            rs_in[i] = rs_ff[i] + CW'(1);
         end
      end
      if (ins) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i <= MAX_ROWS; i++) begin
            rs_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i <= MAX_ROWS; i++) begin
            rs_ff[i] <= rs_in[i];
         end
      end
   end

   assign rd_data = rs_ff[rd_idx];
   assign count   = count_ff;

endmodule

// ----- rtl/csm_seq.sv -----
// Sequencer: range check, row scan with one shared column compare,
// entry shifting on insert, and result emission. Uses csm_pkg.
module csm_seq #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_ROWS+1)-1:0]    nr,
   input  logic                             req_valid,
   input  csm_pkg::req_item_type            req_item,
   output logic                             req_ready,
   input  logic                             out_free,
   output logic                             out_push,
   output csm_pkg::rsp_item_type            out_item,
   output logic [$clog2(MAX_ROWS+1)-1:0]    rs_idx,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] rs_data,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] count,
   output logic                             ins,
   output logic [$clog2(MAX_ROWS+1)-1:0]    ins_row,
   output logic                             ram_we,
   output logic [$clog2(MAX_ENTRIES)-1:0]   ram_waddr,
   output csm_pkg::entry_type               ram_wdata,
   output logic                             ram_re,
   output logic [$clog2(MAX_ENTRIES)-1:0]   ram_raddr,
   input  csm_pkg::entry_type               ram_rdata
);

   localparam int CW    = $clog2(MAX_ENTRIES+1);
   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int RS_AW = $clog2(MAX_ROWS+1);
   localparam int NR_W  = $clog2(MAX_ROWS+1);
   localparam int XW    = (NR_W > csm_pkg::IDX_W) ? NR_W : csm_pkg::IDX_W;

   csm_pkg::seq_state_type state_ff, state_in;

   logic [csm_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [XW-1:0]              row_ff, row_in;
   logic [XW-1:0]              col_ff, col_in;
   logic [csm_pkg::VAL_W-1:0]  wv_ff, wv_in;
   logic [CW-1:0]              j_ff, j_in;
   logic [CW-1:0]              end_ff, end_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [XW-1:0]              p_ff, p_in;
   logic                       hit_ff, hit_in;
   logic [csm_pkg::VAL_W-1:0]  val_ff, val_in;
   logic [csm_pkg::STAT_W-1:0] status_ff, status_in;

   logic          is_vec, err, full, vec_last, more;
   logic          col_eq, col_gt;
   logic [XW-1:0] nr_x, ent_col, lk_row, lk_tgt;
   logic [CW-1:0] km1;

   // Decode and shared compare
   always_comb begin
      nr_x     = XW'(nr);
      is_vec   = (func_ff == csm_pkg::FUNC_GET_ROW) || (func_ff == csm_pkg::FUNC_GET_COL) ||
                 (func_ff == csm_pkg::FUNC_GET_DIAG);
      err      = (func_ff > csm_pkg::FUNC_GET_DIAG) ||
                 ((func_ff <= csm_pkg::FUNC_GET_ROW) && (row_ff >= nr_x)) ||
                 (((func_ff == csm_pkg::FUNC_READ) || (func_ff == csm_pkg::FUNC_WRITE) ||
                   (func_ff == csm_pkg::FUNC_GET_COL)) && (col_ff >= nr_x));
      full     = (count == CW'(MAX_ENTRIES));
      vec_last = (p_ff == (nr_x - XW'(1)));
      more     = is_vec && (status_ff == csm_pkg::STAT_OK) && !vec_last;
      // lookup coordinates per operation
      lk_row   = (func_ff == csm_pkg::FUNC_GET_COL || func_ff == csm_pkg::FUNC_GET_DIAG) ?
                 p_ff : row_ff;
      lk_tgt   = (func_ff == csm_pkg::FUNC_GET_ROW || func_ff == csm_pkg::FUNC_GET_DIAG) ?
                 p_ff : col_ff;
      ent_col  = XW'(ram_rdata.col);
      col_eq   = (ent_col == lk_tgt);
      col_gt   = (ent_col > lk_tgt);
      km1      = k_ff - CW'(1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csm_pkg::S_IDLE: begin
            if (req_valid) state_in = csm_pkg::S_CHECK;
         end
         csm_pkg::S_CHECK: begin
            state_in = err ? csm_pkg::S_EMIT : csm_pkg::S_BASE;
         end
         csm_pkg::S_BASE:  state_in = csm_pkg::S_LIMIT;
         csm_pkg::S_LIMIT: state_in = csm_pkg::S_FETCH;
         csm_pkg::S_FETCH: begin
            state_in = (j_ff >= end_ff) ? csm_pkg::S_RESOLVE : csm_pkg::S_COMPARE;
         end
         csm_pkg::S_COMPARE: begin
            state_in = (col_eq || col_gt) ? csm_pkg::S_RESOLVE : csm_pkg::S_FETCH;
         end
         csm_pkg::S_RESOLVE: begin
            if (func_ff != csm_pkg::FUNC_WRITE) state_in = csm_pkg::S_EMIT;
            else if (hit_ff)                     state_in = csm_pkg::S_UPDATE;
            else if (full)                       state_in = csm_pkg::S_EMIT;
            else                                 state_in = csm_pkg::S_SHIFT_RD;
         end
         csm_pkg::S_UPDATE: state_in = csm_pkg::S_EMIT;
         csm_pkg::S_SHIFT_RD: begin
            state_in = (k_ff > j_ff) ? csm_pkg::S_SHIFT_WR : csm_pkg::S_INSERT;
         end
         csm_pkg::S_SHIFT_WR: state_in = csm_pkg::S_SHIFT_RD;
         csm_pkg::S_INSERT:   state_in = csm_pkg::S_EMIT;
         csm_pkg::S_EMIT: begin
            if (out_free) begin
               if (!more)                              state_in = csm_pkg::S_IDLE;
               else if (func_ff == csm_pkg::FUNC_GET_ROW) state_in = csm_pkg::S_FETCH;
               else                                    state_in = csm_pkg::S_BASE;
            end
         end
         default: state_in = csm_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      func_in   = func_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      wv_in     = wv_ff;
      j_in      = j_ff;
      end_in    = end_ff;
      k_in      = k_ff;
      p_in      = p_ff;
      hit_in    = hit_ff;
      val_in    = val_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      out_push  = 1'b0;
      rs_idx    = RS_AW'(lk_row);
      ins       = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = j_ff[AW-1:0];
      ram_wdata = '{col: col_ff[csm_pkg::IDX_W-1:0], value: wv_ff};
      ram_re    = 1'b0;
      ram_raddr = j_ff[AW-1:0];
      unique case (state_ff)
         csm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = req_item.func;
               row_in  = XW'(req_item.row_index);
               col_in  = XW'(req_item.col_index);
               wv_in   = req_item.write_value;
               p_in    = '0;
            end
         end
         csm_pkg::S_CHECK: begin
            status_in = err ? csm_pkg::STAT_RANGE : csm_pkg::STAT_OK;
            val_in    = '0;
            hit_in    = 1'b0;
         end
         csm_pkg::S_BASE: begin
            j_in = rs_data;
         end
         csm_pkg::S_LIMIT: begin
            rs_idx = RS_AW'(lk_row) + RS_AW'(1);
            end_in = rs_data;
         end
         csm_pkg::S_FETCH: begin
            if (j_ff >= end_ff) begin
               hit_in = 1'b0;
               val_in = '0;
            end else begin
               ram_re = 1'b1;
            end
         end
         csm_pkg::S_COMPARE: begin
            // columns ascend in a row: a larger column ends the search
            if (col_eq) begin
               hit_in = 1'b1;
               val_in = ram_rdata.value;
            end else if (col_gt) begin
               hit_in = 1'b0;
               val_in = '0;
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         csm_pkg::S_RESOLVE: begin
            if ((func_ff == csm_pkg::FUNC_WRITE) && !hit_ff) begin
               if (full) status_in = csm_pkg::STAT_FULL;
               else      k_in      = count;
            end
         end
         csm_pkg::S_UPDATE: begin
            ram_we = 1'b1;
            val_in = '0;
         end
         csm_pkg::S_SHIFT_RD: begin
            if (k_ff > j_ff) begin
               ram_re    = 1'b1;
               ram_raddr = km1[AW-1:0];
            end
         end
         csm_pkg::S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = k_ff[AW-1:0];
            ram_wdata = ram_rdata;
            k_in      = km1;
         end
         csm_pkg::S_INSERT: begin
            ram_we = 1'b1;
            ins    = 1'b1;
            val_in = '0;
         end
         csm_pkg::S_EMIT: begin
            if (out_free) begin
               out_push = 1'b1;
               if (more) p_in = p_ff + XW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign ins_row = RS_AW'(row_ff);

   // Result item
   always_comb begin
      out_item.read_value = val_ff;
      out_item.position   = csm_pkg::POS_W'(p_ff);
      out_item.status     = status_ff;
      out_item.last       = !more;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      wv_ff     <= wv_in;
      j_ff      <= j_in;
      end_ff    <= end_in;
      k_ff      <= k_in;
      p_ff      <= p_in;
      hit_ff    <= hit_in;
      val_ff    <= val_in;
      status_ff <= status_in;
   end

`ifndef NO_ASSERTIONS
   // compare only ever sees data fetched the cycle before
   a_compare_after_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == csm_pkg::S_COMPARE |-> $past(state_ff) == csm_pkg::S_FETCH)
      else $error("compare without a preceding fetch");

   // shifting never moves an entry below the insert slot
   a_shift_above_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == csm_pkg::S_SHIFT_WR |-> k_ff > j_ff)
      else $error("shift at or below insert slot");

   // inserts happen only with room left
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == csm_pkg::S_INSERT |-> !full)
      else $error("insert into full store");

   // the final result of an item returns the sequencer to idle
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      out_push && out_item.last |=> state_ff == csm_pkg::S_IDLE)
      else $error("item continues after last result");
`endif

endmodule

// ----- rtl/csr_sparse_matrix_store_top.sv -----
// Top level of the compressed-row sparse matrix store: register port,
// result register, sequencer, row table, entry memory. Uses csm_pkg.
//
//  Channel | Ports                                   | Moves
//  --------+-----------------------------------------+---------------------------
//  request | req_valid, req_ready, req_item          | one operation per item
//  result  | rsp_valid, rsp_ready, rsp_item          | 1 or num_rows words/item
//  config  | psel, penable, pwrite, paddr, pwdata,   | num_rows at address 0
//          | prdata, pready                          |
//
// One item at a time. A read or write scans the entries of its row; an update rewrites
// the entry in place, and an insert first shifts every later entry up one slot. A row
// vector scans its row once; a column or diagonal rescans a row for each word. Reset
// is immediate: row starts and count clear, no memory sweep. A stalled result
// register holds the sequencer.
module csr_sparse_matrix_store_top #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output csm_pkg::rsp_item_type rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int CW    = $clog2(MAX_ENTRIES+1);
   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int RS_AW = $clog2(MAX_ROWS+1);
   localparam int NR_W  = $clog2(MAX_ROWS+1);

   logic [NR_W-1:0] nr_ff, nr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   csm_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                  out_free, out_push;
   csm_pkg::rsp_item_type out_item;
   logic [RS_AW-1:0]      rs_idx, ins_row;
   logic [CW-1:0]         rs_data, count;
   logic                  ins, ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   csm_pkg::entry_type    ram_wdata, ram_rdata;

   // Register write with clamping to 1..MAX_ROWS
   always_comb begin
      nr_in = nr_ff;
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         if (pwdata == 32'd0)                nr_in = NR_W'(1);
         else if (pwdata > 32'(MAX_ROWS))    nr_in = NR_W'(MAX_ROWS);
         else                                nr_in = NR_W'(pwdata);
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? 32'(nr_ff) : 32'd0;

   // Result register between the sequencer and the result channel
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_push) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = out_item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_ff        <= NR_W'(MAX_ROWS);
         rsp_valid_ff <= 1'b0;
      end else begin
         nr_ff        <= nr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   csm_entry_ram #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   csm_row_table #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_rows (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rs_idx),
      .rd_data (rs_data),
      .count   (count),
      .ins     (ins),
      .ins_row (ins_row)
   );

   csm_seq #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .nr        (nr_ff),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_ready (req_ready),
      .out_free  (out_free),
      .out_push  (out_push),
      .out_item  (out_item),
      .rs_idx    (rs_idx),
      .rs_data   (rs_data),
      .count     (count),
      .ins       (ins),
      .ins_row   (ins_row),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

endmodule

// ----- sim/csr_sparse_matrix_store_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the sparse matrix store: a dense model of the matrix, a queue
// of expected result words and a field-by-field compare.
// Watches the request, result and register channels; depends on csm_pkg.
module csr_sparse_matrix_store_checker #(
   parameter int         MAX_ROWS      = 16,
   parameter int         MAX_ENTRIES   = 256,
   parameter logic [2:0] NUM_ROWS_ADDR = 3'd0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  csm_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  csm_pkg::rsp_item_type rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    results_pending
);

   localparam int MAX_PRINTED = 40;

   // Dense image of the stored matrix; presence stands in for the row scan
   logic [csm_pkg::VAL_W-1:0] elem_value   [MAX_ROWS][MAX_ROWS];
   logic                      elem_present [MAX_ROWS][MAX_ROWS];
   int                        stored_count;
   int                        dim_rows;

   csm_pkg::rsp_item_type     expected_words[$];
   csm_pkg::rsp_item_type     oldest;
   int                        word_number;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t: mismatch at result %0d: %s", $time, word_number, msg);
      mismatch_count++;
   endtask

   task automatic push_word(input logic [csm_pkg::VAL_W-1:0] value, input int pos,
                            input logic [csm_pkg::STAT_W-1:0] status, input logic last);
      csm_pkg::rsp_item_type w;
      w.read_value = value;
      w.position   = pos[csm_pkg::POS_W-1:0];
      w.status     = status;
      w.last       = last;
      expected_words.push_back(w);
   endtask

   // Expected result words for one accepted item; updates the matrix image
   task automatic predict_results(input csm_pkg::req_item_type item);
      int                        r;
      int                        c;
      int                        i;
      int                        er;
      int                        ec;
      bit                        in_range;
      logic [csm_pkg::VAL_W-1:0] word;
      r = int'(item.row_index);
      c = int'(item.col_index);
      case (item.func)
         csm_pkg::FUNC_READ, csm_pkg::FUNC_WRITE:
                                 in_range = (r < dim_rows) && (c < dim_rows);
         csm_pkg::FUNC_GET_ROW:  in_range = r < dim_rows;
         csm_pkg::FUNC_GET_COL:  in_range = c < dim_rows;
         csm_pkg::FUNC_GET_DIAG: in_range = 1'b1;
         default:                in_range = 1'b0;
      endcase
      if (!in_range) begin
         push_word('0, 0, csm_pkg::STAT_RANGE, 1'b1);
      end else if (item.func == csm_pkg::FUNC_READ) begin
         push_word(elem_present[r][c] ? elem_value[r][c] : '0, 0, csm_pkg::STAT_OK, 1'b1);
      end else if (item.func == csm_pkg::FUNC_WRITE) begin
         if (elem_present[r][c]) begin
            elem_value[r][c] = item.write_value;
            push_word('0, 0, csm_pkg::STAT_OK, 1'b1);
         end else if (stored_count >= MAX_ENTRIES) begin
            push_word('0, 0, csm_pkg::STAT_FULL, 1'b1);
         end else begin
            elem_present[r][c] = 1'b1;
            elem_value[r][c]   = item.write_value;
            stored_count++;
            push_word('0, 0, csm_pkg::STAT_OK, 1'b1);
         end
      end else begin
         // Dense vector over the active dimension
         for (i = 0; i < dim_rows; i++) begin
            case (item.func)
               csm_pkg::FUNC_GET_ROW: begin er = r; ec = i; end
               csm_pkg::FUNC_GET_COL: begin er = i; ec = c; end
               default:               begin er = i; ec = i; end
            endcase
            word = elem_present[er][ec] ? elem_value[er][ec] : '0;
            push_word(word, i, csm_pkg::STAT_OK, i + 1 == dim_rows);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (elem_present[i, j]) elem_present[i][j] = 1'b0;
         stored_count   = 0;
         dim_rows       = MAX_ROWS;
         word_number    = 0;
         mismatch_count = 0;
         expected_words.delete();
      end else begin
         // Register write, clamped to 1..MAX_ROWS
         if (psel && penable && pwrite && pready && paddr == NUM_ROWS_ADDR) begin
            if (pwdata == 32'd0)
               dim_rows = 1;
            else if (pwdata > MAX_ROWS)
               dim_rows = MAX_ROWS;
            else
               dim_rows = int'(pwdata);
         end
         // Result side: compare against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected result %p", rsp_item));
            end else begin
               oldest = expected_words.pop_front();
               if (rsp_item.read_value !== oldest.read_value)
                  report_mismatch($sformatf("read_value %h, expected %h",
                                            rsp_item.read_value, oldest.read_value));
               if (rsp_item.position !== oldest.position)
                  report_mismatch($sformatf("position %0d, expected %0d",
                                            rsp_item.position, oldest.position));
               if (rsp_item.status !== oldest.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_item.status, oldest.status));
               if (rsp_item.last !== oldest.last)
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_item.last, oldest.last));
            end
            word_number++;
         end
         if (req_valid && req_ready)
            predict_results(req_item);
      end
      results_pending <= expected_words.size();
   end

endmodule

// ----- sim/csr_sparse_matrix_store_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the sparse matrix store: clock, reset, request and register
// stimulus, result-side backpressure and the verdict.
// Depends on csm_pkg, csr_sparse_matrix_store_top and the result checker.
module csr_sparse_matrix_store_top_tb;

   localparam int         MAX_ROWS       = 16;
   localparam int         MAX_ENTRIES    = 256;
   localparam logic [2:0] NUM_ROWS_ADDR  = 3'd0;
   localparam int         CYCLE_LIMIT    = 1_500_000;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         CONFIG_PAUSE   = 40;
   localparam int         SETTLE_CYCLES  = 600;

   // Selectors past the last operation
   localparam logic [csm_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = csm_pkg::FUNC_GET_DIAG + 3'd1;
   localparam logic [csm_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   localparam logic [csm_pkg::VAL_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   csm_pkg::req_item_type req_item  = '0;
   logic                  rsp_ready = 1'b0;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [2:0]            paddr     = '0;
   logic [31:0]           pwdata    = '0;

   logic                  req_ready;
   logic                  rsp_valid;
   csm_pkg::rsp_item_type rsp_item;
   logic [31:0]           prdata;
   logic                  pready;

   int           mismatch_count;
   int           results_pending;

   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   logic         hold_toggle   = 1'b0;
   logic         hold_seen     = 1'b0;
   int           hold_left     = 0;
   int           cycle_count   = 0;
   int           dim_rows      = MAX_ROWS;

   csr_sparse_matrix_store_top #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   csr_sparse_matrix_store_checker #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_ENTRIES   (MAX_ENTRIES),
      .NUM_ROWS_ADDR (NUM_ROWS_ADDR)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item        (rsp_item),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("csr_sparse_matrix_store_top_tb NOT OK");
         $finish;
      end
   end

   // Result side: random stalls, or a long hold-off when the toggle flips
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >= stall_pct;
      end
   end

   function automatic csm_pkg::req_item_type make_op(
      input logic [csm_pkg::FUNC_W-1:0] func,
      input logic [csm_pkg::IDX_W-1:0]  row,
      input logic [csm_pkg::IDX_W-1:0]  col,
      input logic [csm_pkg::VAL_W-1:0]  value);
      csm_pkg::req_item_type item;
      item.func        = func;
      item.row_index   = row;
      item.col_index   = col;
      item.write_value = value;
      return item;
   endfunction

   // Mostly inside the active dimension so lookups hit stored entries
   function automatic logic [csm_pkg::IDX_W-1:0] random_index();
      logic [csm_pkg::IDX_W-1:0] idx;
      if ($urandom_range(0, 99) < 88)
         idx = csm_pkg::IDX_W'($urandom_range(0, dim_rows - 1));
      else
         idx = csm_pkg::IDX_W'($urandom_range(0, MAX_ROWS - 1));
      return idx;
   endfunction

   function automatic logic [csm_pkg::VAL_W-1:0] random_value();
      logic [csm_pkg::VAL_W-1:0] value;
      case ($urandom_range(0, 9))
         0:       value = '0;
         1:       value = ALL_ONES;
         default: value = {$urandom, $urandom};
      endcase
      return value;
   endfunction

   // Write-heavy mix so the store fills and inserts shift many entries
   function automatic csm_pkg::req_item_type random_op();
      csm_pkg::req_item_type item;
      int                    pick;
      pick             = $urandom_range(0, 99);
      item.row_index   = random_index();
      item.col_index   = random_index();
      item.write_value = random_value();
      if (pick < 40)
         item.func = csm_pkg::FUNC_WRITE;
      else if (pick < 62)
         item.func = csm_pkg::FUNC_READ;
      else if (pick < 74)
         item.func = csm_pkg::FUNC_GET_ROW;
      else if (pick < 86)
         item.func = csm_pkg::FUNC_GET_COL;
      else if (pick < 95)
         item.func = csm_pkg::FUNC_GET_DIAG;
      else
         item.func = csm_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
      return item;
   endfunction

   // Offer one item; valid stays up across back-to-back items
   task automatic send_item(input csm_pkg::req_item_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_item(random_op());
   endtask

   // Stop offering and wait until every expected word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // Register write while the block is idle: setup cycle, then access cycle
   task automatic write_num_rows(input logic [4:0] value);
      wait_drained();
      repeat (CONFIG_PAUSE) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= NUM_ROWS_ADDR;
      pwdata  <= {27'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (value == 5'd0)
         dim_rows = 1;
      else if (value > MAX_ROWS)
         dim_rows = MAX_ROWS;
      else
         dim_rows = int'(value);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty read, corner elements, out-of-order inserts, update, vectors, bad selectors
      send_item(make_op(csm_pkg::FUNC_READ, 4'd0, 4'd0, '0));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd0, 4'd0, ALL_ONES));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd15, 4'd15, '0));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd15, 4'd0, 64'h8000_0000_0000_0000));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd0, 4'd15, 64'h0000_0000_0000_0001));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd7, 4'd11, 64'hDEAD_BEEF_0123_4567));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd7, 4'd3, 64'h0F0F_0F0F_F0F0_F0F0));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd7, 4'd7, 64'h1234_5678_9ABC_DEF0));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd0, 4'd0, 64'h5555_5555_AAAA_AAAA));
      send_item(make_op(csm_pkg::FUNC_READ, 4'd0, 4'd0, '0));
      send_item(make_op(csm_pkg::FUNC_READ, 4'd7, 4'd7, ALL_ONES));
      send_item(make_op(csm_pkg::FUNC_READ, 4'd7, 4'd5, '0));
      send_item(make_op(csm_pkg::FUNC_GET_ROW, 4'd7, 4'd0, '0));
      send_item(make_op(csm_pkg::FUNC_GET_COL, 4'd0, 4'd15, '0));
      send_item(make_op(csm_pkg::FUNC_GET_COL, 4'd15, 4'd0, '0));
      send_item(make_op(csm_pkg::FUNC_GET_DIAG, 4'd0, 4'd0, '0));
      send_item(make_op(FUNC_UNUSED_LO, 4'd15, 4'd15, ALL_ONES));
      send_item(make_op(FUNC_UNUSED_HI, 4'd0, 4'd0, '0));

      // Full dimension, no idling
      run_random(70);

      // Zero taken as one row; sender mostly idle
      write_num_rows(5'd0);
      send_idle_pct = 77;
      run_random(25);

      // Oversize taken as full; long result hold-off fills the block
      write_num_rows(5'd31);
      send_idle_pct = 0;
      stall_pct   <= 77;
      hold_toggle <= ~hold_toggle;
      run_random(70);

      // Shrunken dimension: out-of-range indices, hidden entries
      write_num_rows(5'd9);
      send_idle_pct = 18;
      stall_pct   <= 18;
      send_item(make_op(csm_pkg::FUNC_READ, 4'd9, 4'd0, '0));
      send_item(make_op(csm_pkg::FUNC_WRITE, 4'd0, 4'd12, ALL_ONES));
      send_item(make_op(csm_pkg::FUNC_GET_ROW, 4'd15, 4'd0, '0));
      send_item(make_op(csm_pkg::FUNC_GET_COL, 4'd0, 4'd9, '0));
      send_item(make_op(csm_pkg::FUNC_GET_ROW, 4'd0, 4'd15, '0));
      send_item(make_op(csm_pkg::FUNC_GET_DIAG, 4'd15, 4'd15, '0));
      run_random(50);

      // Just past the maximum, no idling
      write_num_rows(5'd17);
      send_idle_pct = 0;
      stall_pct   <= 0;
      run_random(45);

      // Smallest dimension written directly
      write_num_rows(5'd1);
      send_idle_pct = 18;
      stall_pct   <= 18;
      run_random(20);

      // Back to full size: hidden entries return; sender pauses midway
      write_num_rows(5'd16);
      run_random(40);
      wait_drained();
      run_random(40);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("csr_sparse_matrix_store_top_tb OK");
      else
         $display("csr_sparse_matrix_store_top_tb NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/csm_pkg.sv
rtl/csm_entry_ram.sv
rtl/csm_row_table.sv
rtl/csm_seq.sv
rtl/csr_sparse_matrix_store_top.sv
sim/csr_sparse_matrix_store_checker.sv
sim/csr_sparse_matrix_store_top_tb.sv
